[hdl/vtp_pkg.sv]
// Package: shared constants and types for the vertex transform block
package vtp_pkg;
   localparam int COMP_W    = 32;
   localparam int COEF_W    = 16;
   localparam int NUM_ROWS  = 4;
   localparam int NUM_COMPS = 4;
   localparam int ROW_W     = 64;
   localparam int DIV_W     = 48;
   localparam int QUO_STEPS = 48;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJECT = 3'd4;

   localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
   localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

   // one divider lane: three dividends, one divisor, running remainders
   typedef struct packed {
      logic                     valid;
      logic                     do_div;
      logic                     w_zero;
      logic                     sat;
      logic signed [COMP_W-1:0] w;
      logic [NUM_ROWS-2:0]      neg;
      logic [DIV_W-1:0]         dvd0;
      logic [DIV_W-1:0]         dvd1;
      logic [DIV_W-1:0]         dvd2;
      logic [DIV_W:0]           rem0;
      logic [DIV_W:0]           rem1;
      logic [DIV_W:0]           rem2;
      logic [COMP_W-1:0]        dsr;
      logic signed [COMP_W-1:0] x0;
      logic signed [COMP_W-1:0] x1;
      logic signed [COMP_W-1:0] x2;
   } div_lane_type;

   function automatic logic signed [COMP_W-1:0] sat32(input logic signed [63:0] v,
                                                      output logic s);
      if (v > 64'sd2147483647) begin
         s = 1'b1;
         sat32 = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         s = 1'b1;
         sat32 = 32'sh80000000;
      end else begin
         s = 1'b0;
         sat32 = v[COMP_W-1:0];
      end
   endfunction
endpackage

[hdl/vtp_div_cell.sv]
// One restoring-divide cell: one quotient bit for each of the lane's three dividends per stage
module vtp_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  vtp_pkg::div_lane_type lane_in,
   output vtp_pkg::div_lane_type lane_out
);
   vtp_pkg::div_lane_type lane_ff, lane_in_c;

   function automatic void step(input logic [vtp_pkg::DIV_W:0] r, input logic [vtp_pkg::DIV_W-1:0] d,
                                input logic [vtp_pkg::COMP_W-1:0] s,
                                output logic [vtp_pkg::DIV_W:0] ro, output logic [vtp_pkg::DIV_W-1:0] dout);
      logic [vtp_pkg::DIV_W:0] t;
      t = {r[vtp_pkg::DIV_W-1:0], d[vtp_pkg::DIV_W-1]};
      if (t >= {17'd0, s}) begin
         ro = t - {17'd0, s};
         dout = {d[vtp_pkg::DIV_W-2:0], 1'b1};
      end else begin
         ro = t;
         dout = {d[vtp_pkg::DIV_W-2:0], 1'b0};
      end
   endfunction

   always_comb begin
      lane_in_c = lane_in;
      step(lane_in.rem0, lane_in.dvd0, lane_in.dsr, lane_in_c.rem0, lane_in_c.dvd0);
      step(lane_in.rem1, lane_in.dvd1, lane_in.dsr, lane_in_c.rem1, lane_in_c.dvd1);
      step(lane_in.rem2, lane_in.dvd2, lane_in.dsr, lane_in_c.rem2, lane_in_c.dvd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in_c;
      end
   end

   assign lane_out = lane_ff;
endmodule

[hdl/vtp_row_cell.sv]
// One matrix row: four products, registered, then summed, shifted and saturated
module vtp_row_cell #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [vtp_pkg::ROW_W-1:0]           coefs,
   input  logic signed [vtp_pkg::COMP_W-1:0]   comp0,
   input  logic signed [vtp_pkg::COMP_W-1:0]   comp1,
   input  logic signed [vtp_pkg::COMP_W-1:0]   comp2,
   input  logic signed [vtp_pkg::COMP_W-1:0]   comp3,
   output logic signed [vtp_pkg::COMP_W-1:0]   result,
   output logic                                sat
);
   logic signed [47:0] prod_ff [4];
   logic signed [49:0] sum_ff;
   logic signed [49:0] sum_in;
   logic signed [63:0] shifted;
   logic signed [vtp_pkg::COMP_W-1:0] res_ff, res_in;
   logic sat_ff, sat_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff[0] <= $signed(coefs[15:0])  * comp0;
         prod_ff[1] <= $signed(coefs[31:16]) * comp1;
         prod_ff[2] <= $signed(coefs[47:32]) * comp2;
         prod_ff[3] <= $signed(coefs[63:48]) * comp3;
         sum_ff     <= sum_in;
         res_ff     <= res_in;
         sat_ff     <= sat_in;
      end
   end

   assign sum_in = 50'(prod_ff[0]) + 50'(prod_ff[1]) + 50'(prod_ff[2]) + 50'(prod_ff[3]);
   assign shifted = 64'(sum_ff >>> COEF_FRAC_BITS);
   always_comb res_in = vtp_pkg::sat32(shifted, sat_in);

   assign result = res_ff;
   assign sat    = sat_ff;
endmodule

[hdl/vertex_transform_project_top.sv]
// Top level: 4x4 fixed-point vertex transform with chained perspective divide
// Stages from input transaction to result: three transform registers, one setup,
//   48 divide cells, one fixup/output. Throughput: one vertex per cycle when not stalled.
// The divide is a chain of 48 restoring cells, one quotient bit each.
// The whole pipe advances unless the output register holds an untaken result.
// Synchronous active-high reset clears valids and loads the default matrix.
module vertex_transform_project_top #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // in_x, in_y, in_z, in_w
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // out_x, out_y, out_z, out_w
   output logic [1:0]    rsp_tuser,   // w_was_zero, saturated
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_wdata
);
   localparam int T_LAT = 3;
   localparam int NC = vtp_pkg::QUO_STEPS;

   logic [vtp_pkg::ROW_W-1:0] row_ff [4];
   logic proj_ff;
   logic advance;
   logic [T_LAT-1:0] tv_ff;
   logic signed [31:0] r [4];
   logic rs [4];
   vtp_pkg::div_lane_type chain [NC+1];
   vtp_pkg::div_lane_type setup_ff, setup_in;
   logic out_valid_ff;
   logic [127:0] out_data_ff, out_data_in;
   logic [1:0] out_user_ff, out_user_in;

   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= vtp_pkg::ROW0_RST;
         row_ff[1] <= vtp_pkg::ROW1_RST;
         row_ff[2] <= vtp_pkg::ROW2_RST;
         row_ff[3] <= vtp_pkg::ROW3_RST;
         proj_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            vtp_pkg::CSR_ROW0:    row_ff[0] <= csr_wdata;
            vtp_pkg::CSR_ROW1:    row_ff[1] <= csr_wdata;
            vtp_pkg::CSR_ROW2:    row_ff[2] <= csr_wdata;
            vtp_pkg::CSR_ROW3:    row_ff[3] <= csr_wdata;
            vtp_pkg::CSR_PROJECT: proj_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) tv_ff <= '0;
      else if (advance) tv_ff <= {tv_ff[T_LAT-2:0], req_tvalid};
   end

   for (genvar g = 0; g < 4; g++) begin : g_row
      vtp_row_cell #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row (
         .clock(clock), .advance(advance), .coefs(row_ff[g]),
         .comp0($signed(req_tdata[31:0])),  .comp1($signed(req_tdata[63:32])),
         .comp2($signed(req_tdata[95:64])), .comp3($signed(req_tdata[127:96])),
         .result(r[g]), .sat(rs[g]));
   end

   function automatic logic [31:0] mag(input logic signed [31:0] v);
      mag = v[31] ? 32'(-v) : v;
   endfunction

   always_comb begin
      setup_in.valid  = tv_ff[T_LAT-1];
      setup_in.w_zero = (r[3] == 0);
      setup_in.do_div = proj_ff && (r[3] != 0);
      setup_in.sat    = rs[0] | rs[1] | rs[2] | rs[3];
      setup_in.w      = r[3];
      setup_in.neg    = {r[2][31] ^ r[3][31], r[1][31] ^ r[3][31], r[0][31] ^ r[3][31]};
      setup_in.dvd0   = {mag(r[0]), 16'd0};
      setup_in.dvd1   = {mag(r[1]), 16'd0};
      setup_in.dvd2   = {mag(r[2]), 16'd0};
      setup_in.rem0   = '0;
      setup_in.rem1   = '0;
      setup_in.rem2   = '0;
      setup_in.dsr    = mag(r[3]);
      setup_in.x0     = r[0];
      setup_in.x1     = r[1];
      setup_in.x2     = r[2];
   end

   always_ff @(posedge clock) begin
      if (reset) setup_ff.valid <= 1'b0;
      else if (advance) setup_ff <= setup_in;
   end

   assign chain[0] = setup_ff;

   for (genvar c = 0; c < NC; c++) begin : g_div
      vtp_div_cell u_cell (.clock(clock), .reset(reset), .advance(advance),
                           .lane_in(chain[c]), .lane_out(chain[c+1]));
   end

   function automatic logic signed [31:0] fix(input logic [47:0] q, input logic n,
                                              output logic s);
      logic signed [63:0] v;
      v = n ? -$signed({16'd0, q}) : $signed({16'd0, q});
      fix = vtp_pkg::sat32(v, s);
   endfunction

   always_comb begin
      logic s0, s1, s2;
      logic signed [31:0] q0, q1, q2;
      vtp_pkg::div_lane_type e;
      e = chain[NC];
      q0 = fix(e.dvd0, e.neg[0], s0);
      q1 = fix(e.dvd1, e.neg[1], s1);
      q2 = fix(e.dvd2, e.neg[2], s2);
      if (e.do_div) begin
         out_data_in = {e.w, q2, q1, q0};
         out_user_in = {e.sat | s0 | s1 | s2, e.w_zero};
      end else begin
         out_data_in = {e.w, e.x2, e.x1, e.x0};
         out_user_in = {e.sat, e.w_zero};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[NC].valid;
         out_data_ff  <= out_data_in;
         out_user_ff  <= out_user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
endmodule

[sim/tb.sv]
// Testbench for vertex_transform_project_top: matrix transform and perspective divide
`timescale 1ns / 100ps
module tb;
   typedef struct packed {
      logic [31:0] x, y, z, w;
      logic        wz, sat;
   } vertex_out_type;

   typedef struct {
      logic [31:0]    x, y, z, w;
      logic           chk;
      vertex_out_type res;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [63:0]   csr_wdata = '0;

   logic [63:0]    mtx [4];
   logic           proj_en;
   vertex_out_type pending_vertices [$];
   int             errors = 0;
   logic           sink_hold = 1'b0;
   logic           hold_go = 1'b0;

   vertex_transform_project_top DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic signed [63:0] clamp_q16(input logic signed [63:0] v,
                                                     inout logic s);
      if (v > 64'sd2147483647) begin
         s = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         s = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic vertex_out_type transform_vertex(input logic [31:0] x, y, z, w);
      logic signed [63:0] comp [4];
      logic signed [63:0] r [4];
      logic signed [63:0] acc;
      logic signed [15:0] cf;
      logic               s;
      vertex_out_type     o;
      s = 1'b0;
      comp[0] = $signed(x);
      comp[1] = $signed(y);
      comp[2] = $signed(z);
      comp[3] = $signed(w);
      for (int i = 0; i < 4; i++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) begin
            cf = mtx[i][16*c +: 16];
            acc += 64'(cf) * comp[c];
         end
         r[i] = clamp_q16(acc >>> 12, s);
      end
      if (proj_en && r[3] != 0)
         for (int i = 0; i < 3; i++)
            r[i] = clamp_q16((r[i] * 64'sd65536) / r[3], s);
      o.x = r[0][31:0];
      o.y = r[1][31:0];
      o.z = r[2][31:0];
      o.w = r[3][31:0];
      o.wz = (r[3] == 0);
      o.sat = s;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
      $display("mismatch %s: got %h expected %h", what, got, exp_v);
      errors++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx < vtp_pkg::CSR_PROJECT) mtx[idx] = val;
      else proj_en = val[0];
   endtask

   // leaves tvalid high after the transaction; a random gap in the next call, or drain, takes it down
   task automatic send_vertex(input logic [31:0] x, y, z, w, input logic chk,
                              input vertex_out_type res);
      vertex_out_type e;
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end else if ($urandom_range(0, 40) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(10, 70)) @(negedge clock);
      end
      req_tdata  <= {w, z, y, x};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      e = transform_vertex(x, y, z, w);
      pending_vertices.push_back(chk ? res : e);
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_comp;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         1: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
         2: return $urandom & 32'h000fffff;
         3: return -($urandom & 32'h000fffff);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] rand_row;
      logic [63:0] r;
      for (int c = 0; c < 4; c++)
         case ($urandom_range(0, 3))
            0: r[16*c +: 16] = 16'h0000;
            1: r[16*c +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: r[16*c +: 16] = 16'($urandom);
         endcase
      return r;
   endfunction

   // result sink
   always @(posedge clock) begin
      vertex_out_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[31:0], '0);
         end else begin
            e = pending_vertices.pop_front();
            if (rsp_tdata[31:0]   !== e.x) report_mismatch("out_x", rsp_tdata[31:0], e.x);
            if (rsp_tdata[63:32]  !== e.y) report_mismatch("out_y", rsp_tdata[63:32], e.y);
            if (rsp_tdata[95:64]  !== e.z) report_mismatch("out_z", rsp_tdata[95:64], e.z);
            if (rsp_tdata[127:96] !== e.w) report_mismatch("out_w", rsp_tdata[127:96], e.w);
            if (rsp_tuser[0] !== e.wz)  report_mismatch("w_was_zero", rsp_tuser[0], e.wz);
            if (rsp_tuser[1] !== e.sat) report_mismatch("saturated", rsp_tuser[1], e.sat);
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (sink_hold) begin
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 59) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   // long receiver hold-off so the pipe fills and stalls the input
   initial begin
      wait (hold_go);
      sink_hold = 1'b1;
      repeat (150) @(negedge clock);
      sink_hold = 1'b0;
   end

   initial begin
      stim_row_type dir [$];
      vertex_out_type z0;
      z0 = '0;
      mtx[0] = vtp_pkg::ROW0_RST; mtx[1] = vtp_pkg::ROW1_RST;
      mtx[2] = vtp_pkg::ROW2_RST; mtx[3] = vtp_pkg::ROW3_RST;
      proj_en = 1'b1;
      // identity after reset: w of zero skips the divide
      dir.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{0, 0, 0, 0, 1'b1, 1'b0}});
      dir.push_back('{32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, 1'b1,
                      '{32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, 1'b0, 1'b0}});
      dir.push_back('{32'h7fffffff, 32'h0, 32'h0, 32'h00008000, 1'b1,
                      '{32'h7fffffff, 0, 0, 32'h00008000, 1'b0, 1'b1}});
      dir.push_back('{32'h80000000, 32'h0, 32'h0, 32'h00008000, 1'b1,
                      '{32'h80000000, 0, 0, 32'h00008000, 1'b0, 1'b1}});
      dir.push_back('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, z0});
      dir.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b0, z0});
      dir.push_back('{32'hffffffff, 32'h00000001, 32'hffff0000, 32'h00000001, 1'b0, z0});
      dir.push_back('{32'h12345678, 32'hfedcba98, 32'h55555555, 32'haaaaaaaa, 1'b0, z0});
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir[i]) send_vertex(dir[i].x, dir[i].y, dir[i].z, dir[i].w, dir[i].chk, dir[i].res);
      drain();
      // projection off, then extreme coefficients
      csr_write(vtp_pkg::CSR_PROJECT, 64'h0);
      send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 32'h0, 1'b1,
                  '{32'h00010000, 32'h00020000, 32'h00030000, 0, 1'b1, 1'b0});
      send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, z0);
      drain();
      csr_write(vtp_pkg::CSR_ROW0, 64'h7fff_7fff_7fff_7fff);
      csr_write(vtp_pkg::CSR_ROW1, 64'h8000_8000_8000_8000);
      csr_write(vtp_pkg::CSR_ROW2, 64'hffff_ffff_ffff_ffff);
      csr_write(vtp_pkg::CSR_ROW3, 64'h0000_0000_0000_0000);
      foreach (dir[i]) send_vertex(dir[i].x, dir[i].y, dir[i].z, dir[i].w, 1'b0, z0);
      drain();
      csr_write(vtp_pkg::CSR_PROJECT, 64'hffff_ffff_ffff_fffe);
      csr_write(vtp_pkg::CSR_ROW3, 64'h8000_7fff_0001_ffff);
      foreach (dir[i]) send_vertex(dir[i].x, dir[i].y, dir[i].z, dir[i].w, 1'b0, z0);
      drain();
      // random phases with fresh settings; sender pauses for a full drain between
      for (int ph = 0; ph < 10; ph++) begin
         for (int r = 0; r < 4; r++) csr_write(r[2:0], rand_row());
         if (ph % 3 == 2) csr_write(vtp_pkg::CSR_ROW3, 64'h1000_0000_0000_0000);
         csr_write(vtp_pkg::CSR_PROJECT, {$urandom, $urandom});
         if (ph == 1) hold_go = 1'b1;
         for (int n = 0; n < 52; n++)
            send_vertex(rand_comp(), rand_comp(), rand_comp(),
                        ($urandom_range(0, 9) == 0) ? 32'h0 : rand_comp(), 1'b0, z0);
         drain();
      end
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
